@@ rtl/nfs_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and the quarter-wave sine generator for the frequency-shift unit.
// No dependencies; every file but nfs_fifo refers to it by scoped names.
package nfs_pkg;

    // Phase counter and frequency offset width
    localparam int PH_W = 21;

    // Exponential average shifts
    localparam int AVG_SHIFT   = 21;
    localparam int LEVEL_SHIFT = 17;

    // Depth of the queues between front, back and result port
    localparam int QUEUE_DEPTH = 4;

    // Odd Taylor coefficients of sin(pi/2 * x), Q30
    localparam logic [63:0] SIN_C1 = 64'd1686629713;
    localparam logic [63:0] SIN_C3 = 64'd693598669;
    localparam logic [63:0] SIN_C5 = 64'd85569306;
    localparam logic [63:0] SIN_C7 = 64'd5026995;
    localparam logic [63:0] SIN_C9 = 64'd172272;

    // Quarter-wave sine entry for address a, Q1.15, evaluated at elaboration
    function automatic logic [15:0] rom_sin(input logic [63:0] a, input int abits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] r;
        x  = a << (30 - abits);
        x2 = (x * x) >> 30;
        p  = SIN_C9;
        p  = SIN_C7 - ((x2 * p) >> 30);
        p  = SIN_C5 - ((x2 * p) >> 30);
        p  = SIN_C3 - ((x2 * p) >> 30);
        p  = SIN_C1 - ((x2 * p) >> 30);
        s  = (x * p) >> 30;
        r  = (s + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[15:0];
    endfunction

endpackage

@@ rtl/nco_frequency_shift_with_level_track_unit.sv @@
`timescale 1ns / 1ps
// Top level of the frequency-shift mixer with level tracking.
// Depends on nfs_pkg, nfs_front, nfs_fifo and nfs_back.
//
// Use: both sides look like a queue. A sample request is taken at a clock edge
// with push high and full low; each request yields exactly one result, shown
// on the o_ ports while empty is low and taken at an edge with pop high.
// The front pipeline (6 stages) reduces the frequency offset modulo the phase
// modulus, steps the phase counter and updates the |I|, |Q| and level averages;
// a 4-entry queue carries its requests to the back pipeline (7 stages), which
// turns the phase into a table index, reads the quarter-wave table at two
// addresses, rotates the sample and rounds; a second 4-entry queue holds results.
// Throughput: one sample per cycle while full is low; the phase step, the
// 38-bit |I|/|Q| average updates and the 34-bit level average update each
// close combinationally, and the table is read at two addresses at once.
// Reset clears the phase counter and |I|/|Q| averages, sets the level to one
// tenth of full scale and empties both queues. When the receiver stops popping,
// the result queue fills, then the back pipeline, the middle queue and the front
// pipeline hold in turn, and full rises; nothing is dropped.
module nco_frequency_shift_with_level_track_unit #(
    parameter int PHASE_MODULUS = 2048000,
    parameter int ROM_ADDR_BITS = 12,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample_i,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample_q,
    input  logic signed [nfs_pkg::PH_W-1:0] i_freq_offset,
    input  logic                            i_last_of_block,
    output logic                            empty,
    input  logic                            pop,
    output logic signed [SAMPLE_BITS-1:0]   o_out_i,
    output logic signed [SAMPLE_BITS-1:0]   o_out_q,
    output logic [SAMPLE_BITS-1:0]          o_signal_level,
    output logic [SAMPLE_BITS-1:0]          o_avg_abs_i,
    output logic [SAMPLE_BITS-1:0]          o_avg_abs_q,
    output logic                            o_block_end
);

    localparam int SB     = SAMPLE_BITS;
    localparam int ITEM_W = nfs_pkg::PH_W + 5 * SB + 1;
    localparam int RES_W  = 5 * SB + 1;

    logic              w_item_push;
    logic              w_item_full;
    logic              w_item_pop;
    logic              w_item_empty;
    logic [ITEM_W-1:0] w_item_in;
    logic [ITEM_W-1:0] w_item_out;
    logic              w_res_push;
    logic              w_res_full;
    logic [RES_W-1:0]  w_res_in;
    logic [RES_W-1:0]  w_res_out;

    // Accept requests, reduce the offset, advance phase and averages
    nfs_front #(
        .PHASE_MODULUS (PHASE_MODULUS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .o_full          (full),
        .i_sample_i      (i_sample_i),
        .i_sample_q      (i_sample_q),
        .i_freq_offset   (i_freq_offset),
        .i_last_of_block (i_last_of_block),
        .o_item_push     (w_item_push),
        .i_item_full     (w_item_full),
        .o_item          (w_item_in)
    );

    // Decouple front and back
    nfs_fifo #(
        .DATA_W (ITEM_W),
        .DEPTH  (nfs_pkg::QUEUE_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_item_push),
        .i_data  (w_item_in),
        .o_full  (w_item_full),
        .i_pop   (w_item_pop),
        .o_data  (w_item_out),
        .o_empty (w_item_empty)
    );

    // Index the table, rotate and round
    nfs_back #(
        .PHASE_MODULUS (PHASE_MODULUS),
        .ROM_ADDR_BITS (ROM_ADDR_BITS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item_out),
        .i_item_empty (w_item_empty),
        .o_item_pop   (w_item_pop),
        .o_res_push   (w_res_push),
        .i_res_full   (w_res_full),
        .o_res        (w_res_in)
    );

    // Hold results until the receiver pops them
    nfs_fifo #(
        .DATA_W (RES_W),
        .DEPTH  (nfs_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_in),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_out_i        = $signed(w_res_out[RES_W-1 -: SB]);
    assign o_out_q        = $signed(w_res_out[RES_W-SB-1 -: SB]);
    assign o_signal_level = w_res_out[3*SB -: SB];
    assign o_avg_abs_i    = w_res_out[2*SB -: SB];
    assign o_avg_abs_q    = w_res_out[SB:1];
    assign o_block_end    = w_res_out[0];

    // The back part never pushes into a full result queue
    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_res_push && w_res_full))
        else $error("result queue overflow");

    // The front part never pushes into a full middle queue
    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_item_push && w_item_full))
        else $error("middle queue overflow");

    // Input back-pressure only arises from a full middle queue
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_item_full)
        else $error("full raised without a full middle queue");

    // Reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

endmodule

@@ rtl/nfs_fifo.sv @@
`timescale 1ns / 1ps
// Small register queue with full/empty flags, used between the pipeline parts.
// Depends on nothing but its parameters.
module nfs_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Hold queued entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

@@ rtl/nfs_front.sv @@
`timescale 1ns / 1ps
// Front part: accepts samples, reduces the offset, advances phase and level averages.
// Depends on nfs_pkg.
module nfs_front #(
    parameter int PHASE_MODULUS = 2048000,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_push,
    output logic                                     o_full,
    input  logic signed [SAMPLE_BITS-1:0]            i_sample_i,
    input  logic signed [SAMPLE_BITS-1:0]            i_sample_q,
    input  logic signed [nfs_pkg::PH_W-1:0]          i_freq_offset,
    input  logic                                     i_last_of_block,
    output logic                                     o_item_push,
    input  logic                                     i_item_full,
    output logic [nfs_pkg::PH_W+5*SAMPLE_BITS:0]     o_item
);

    localparam int    PW      = nfs_pkg::PH_W;
    localparam int    SB      = SAMPLE_BITS;
    localparam int    RW      = PW + 1;
    localparam int    AS      = nfs_pkg::AVG_SHIFT;
    localparam int    LS      = nfs_pkg::LEVEL_SHIFT;
    localparam int    AW      = SB + AS + 1;
    localparam int    LW      = SB + LS + 1;
    localparam int    PAY_W   = 2 * SB + 1;
    localparam longint RF     = (longint'(1) << PW) / PHASE_MODULUS;
    localparam int    Q_W     = $clog2(RF + 1);
    localparam int    MW      = PW + Q_W;
    localparam longint WRAP_L = (longint'(1) << PW) % PHASE_MODULUS;
    localparam longint LVL_RST_L = ((longint'(1) << (SB - 1 + LS)) + 5) / 10;
    localparam logic [PW-1:0] MOD     = PW'(PHASE_MODULUS);
    localparam logic [PW-1:0] WRAP    = PW'(WRAP_L);
    localparam logic [LW-1:0] LVL_RST = LW'(LVL_RST_L);

    logic [5:0]        r_v;
    logic              w_en;
    logic              w_accept;
    logic [PAY_W-1:0]  r_pay [1:6];
    logic [PW-1:0]     r_off [1:3];
    logic [MW-1:0]     r_p2;
    logic [RW-1:0]     r_qm3;
    logic [PW-1:0]     r_res4;
    logic              r_neg4;
    logic [PW-1:0]     r_o5;
    logic [PW-1:0]     r_phase;
    logic [AW-1:0]     r_acc_i;
    logic [AW-1:0]     r_acc_q;
    logic [LW-1:0]     r_acc_l;

    logic [Q_W-1:0]    w_q;
    logic [MW-1:0]     w_qm;
    logic [RW-1:0]     w_r;
    logic [RW-1:0]     w_r2;
    logic [RW-1:0]     w_t;
    logic [PW-1:0]     w_o;
    logic [RW-1:0]     w_pd;
    logic [PW-1:0]     n_phase;
    logic signed [SB-1:0] w_si5;
    logic signed [SB-1:0] w_sq5;
    logic [SB-1:0]     w_ai;
    logic [SB-1:0]     w_aq;
    logic [AW-1:0]     n_acc_i;
    logic [AW-1:0]     n_acc_q;
    logic [LW-1:0]     n_acc_l;
    logic [SB:0]       w_lvl;
    logic [SB-1:0]     w_lvl_sat;

    // Pipeline moves whenever its last stage can leave
    assign w_en        = !r_v[5] || !i_item_full;
    assign o_full      = !w_en;
    assign w_accept    = i_push && w_en;
    assign o_item_push = r_v[5] && !i_item_full;

    // Offset modulo: reciprocal estimate, one correction, sign fold
    assign w_q  = r_p2[PW +: Q_W];
    assign w_qm = MW'(w_q) * MW'(MOD);
    assign w_r  = {1'b0, r_off[3]} - r_qm3;
    assign w_r2 = (w_r >= {1'b0, MOD}) ? (w_r - {1'b0, MOD}) : w_r;
    assign w_t  = {1'b0, r_res4} - {1'b0, WRAP};
    assign w_o  = !r_neg4 ? r_res4 : (w_t[PW] ? (w_t[PW-1:0] + MOD) : w_t[PW-1:0]);

    // Phase step, kept in 0 .. modulus-1
    assign w_pd    = {1'b0, r_phase} - {1'b0, r_o5};
    assign n_phase = w_pd[PW] ? (w_pd[PW-1:0] + MOD) : w_pd[PW-1:0];

    // Level tracking on the raw sample magnitudes
    assign w_si5   = $signed(r_pay[5][PAY_W-1 -: SB]);
    assign w_sq5   = $signed(r_pay[5][SB:1]);
    assign w_ai    = w_si5[SB-1] ? SB'(-w_si5) : SB'(w_si5);
    assign w_aq    = w_sq5[SB-1] ? SB'(-w_sq5) : SB'(w_sq5);
    assign n_acc_i = r_acc_i - (r_acc_i >> AS) + AW'(w_ai);
    assign n_acc_q = r_acc_q - (r_acc_q >> AS) + AW'(w_aq);
    assign n_acc_l = r_acc_l - (r_acc_l >> LS) + LW'(w_ai) + LW'(w_aq);

    // Output fields derived from the state left by the item in the last stage
    assign w_lvl     = r_acc_l[LW-1:LS];
    assign w_lvl_sat = w_lvl[SB] ? '1 : w_lvl[SB-1:0];
    assign o_item    = {r_phase, r_pay[6][PAY_W-1:1], w_lvl_sat,
                        r_acc_i[AS +: SB], r_acc_q[AS +: SB], r_pay[6][0]};

    // Hold valid bits and the running state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_phase <= '0;
            r_acc_i <= '0;
            r_acc_q <= '0;
            r_acc_l <= LVL_RST;
        end else if (w_en) begin
            r_v <= {r_v[4:0], w_accept};
            if (r_v[4]) begin
                r_phase <= n_phase;
                r_acc_i <= n_acc_i;
                r_acc_q <= n_acc_q;
                r_acc_l <= n_acc_l;
            end
        end
    end

    // Advance payload through the stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pay[1] <= {i_sample_i, i_sample_q, i_last_of_block};
            for (int s = 2; s <= 6; s++) begin
                r_pay[s] <= r_pay[s-1];
            end
            r_off[1] <= i_freq_offset;
            r_off[2] <= r_off[1];
            r_off[3] <= r_off[2];
            r_p2     <= MW'(r_off[1]) * MW'(RF);
            r_qm3    <= w_qm[RW-1:0];
            r_res4   <= w_r2[PW-1:0];
            r_neg4   <= r_off[3][PW-1];
            r_o5     <= w_o;
        end
    end

endmodule

@@ rtl/nfs_back.sv @@
`timescale 1ns / 1ps
// Back part: phase to table index, quarter-wave lookup, complex rotation, rounding.
// Depends on nfs_pkg.
module nfs_back #(
    parameter int PHASE_MODULUS = 2048000,
    parameter int ROM_ADDR_BITS = 12,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic [nfs_pkg::PH_W+5*SAMPLE_BITS:0] i_item,
    input  logic                                 i_item_empty,
    output logic                                 o_item_pop,
    output logic                                 o_res_push,
    input  logic                                 i_res_full,
    output logic [5*SAMPLE_BITS:0]               o_res
);

    localparam int     PW     = nfs_pkg::PH_W;
    localparam int     SB     = SAMPLE_BITS;
    localparam int     A      = ROM_ADDR_BITS;
    localparam int     K_W    = A + 2;
    localparam int     REM_W  = PW + 2;
    localparam int     PAY_W  = 5 * SB + 1;
    localparam int     ITEM_W = PW + PAY_W;
    localparam longint RK     = ((longint'(1) << PW) * (longint'(4) << A)) / PHASE_MODULUS;
    localparam int     RK_W   = $clog2(RK + 1);
    localparam int     MW     = PW + RK_W;
    localparam int     KM_W   = K_W + PW;
    localparam int     ROM_N  = 1 << A;
    localparam int     PRD_W  = SB + 16;
    localparam int     SUM_W  = SB + 17;
    localparam int     REST_W = 3 * SB + 1;
    localparam logic [PW-1:0]       MOD     = PW'(PHASE_MODULUS);
    localparam logic [A:0]          ROM_TOP = (A + 1)'(ROM_N);
    localparam logic signed [SUM_W-1:0] HALF_LSB = SUM_W'(16384);
    localparam logic signed [SB+1:0] SAT_HI = (SB + 2)'((longint'(1) << (SB - 1)) - 1);
    localparam logic signed [SB+1:0] SAT_LO = (SB + 2)'(-(longint'(1) << (SB - 1)));
    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    logic [6:0]        r_v;
    logic              w_en;
    logic              w_pop;
    logic [PAY_W-1:0]  r_pay [1:6];
    logic [PW-1:0]     r_ph [1:3];
    logic [MW-1:0]     r_pk2;
    logic [K_W-1:0]    r_ke3;
    logic [REM_W-1:0]  r_km3;
    logic [A-1:0]      r_a4;
    logic [1:0]        r_quad4;
    logic [1:0]        r_quad5;
    logic [15:0]       r_sa5;
    logic [15:0]       r_sb5;
    logic signed [PRD_W-1:0] r_ic6;
    logic signed [PRD_W-1:0] r_qs6;
    logic signed [PRD_W-1:0] r_is6;
    logic signed [PRD_W-1:0] r_qc6;
    logic [PAY_W-1:0]  r_res7;

    logic [15:0]       w_rom [0:ROM_N];
    logic [K_W-1:0]    w_ke;
    logic [KM_W-1:0]   w_km;
    logic [PW+K_W-1:0] w_scaled;
    logic [REM_W-1:0]  w_rem;
    logic [K_W-1:0]    w_k;
    logic signed [15:0] w_c;
    logic signed [15:0] w_s;
    logic signed [SB-1:0] w_si5;
    logic signed [SB-1:0] w_sq5;
    logic signed [SUM_W-1:0] w_vi;
    logic signed [SUM_W-1:0] w_vq;

    // Round half up at bit 15 and clamp to the sample range
    function automatic logic [SB-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        logic signed [SB+1:0]    q;
        t = v + HALF_LSB;
        q = $signed(t[SUM_W-1:15]);
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return q[SB-1:0];
    endfunction

    // Quarter-wave table, one entry past the quarter
    for (genvar g = 0; g <= ROM_N; g++) begin : g_rom
        assign w_rom[g] = nfs_pkg::rom_sin(64'(g), A);
    end

    // Pipeline moves whenever its last stage can leave
    assign w_en       = !r_v[6] || !i_res_full;
    assign w_pop      = !i_item_empty && w_en;
    assign o_item_pop = w_pop;
    assign o_res_push = r_v[6] && !i_res_full;
    assign o_res      = r_res7;

    // Table index: reciprocal estimate, then one correction step
    assign w_ke     = r_pk2[PW +: K_W];
    assign w_km     = KM_W'(w_ke) * KM_W'(MOD);
    assign w_scaled = {r_ph[3], {K_W{1'b0}}};
    assign w_rem    = w_scaled[REM_W-1:0] - r_km3;
    assign w_k      = (w_rem >= REM_W'(MOD)) ? (r_ke3 + 1'b1) : r_ke3;

    // Select cos/sin by quadrant
    always_comb begin
        case (r_quad5)
            QUAD_FIRST: begin
                w_c = $signed(r_sb5);
                w_s = $signed(r_sa5);
            end
            QUAD_SECOND: begin
                w_c = -$signed(r_sa5);
                w_s = $signed(r_sb5);
            end
            QUAD_THIRD: begin
                w_c = -$signed(r_sb5);
                w_s = -$signed(r_sa5);
            end
            QUAD_FOURTH: begin
                w_c = $signed(r_sa5);
                w_s = -$signed(r_sb5);
            end
            default: begin
                w_c = $signed(r_sa5);
                w_s = -$signed(r_sb5);
            end
        endcase
    end

    assign w_si5 = $signed(r_pay[5][PAY_W-1 -: SB]);
    assign w_sq5 = $signed(r_pay[5][PAY_W-SB-1 -: SB]);
    assign w_vi  = SUM_W'(r_ic6) - SUM_W'(r_qs6);
    assign w_vq  = SUM_W'(r_is6) + SUM_W'(r_qc6);

    // Hold valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[5:0], w_pop};
        end
    end

    // Advance payload, index, table reads, products and rounded results
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pay[1] <= i_item[PAY_W-1:0];
            for (int s = 2; s <= 6; s++) begin
                r_pay[s] <= r_pay[s-1];
            end
            r_ph[1]  <= i_item[ITEM_W-1 -: PW];
            r_ph[2]  <= r_ph[1];
            r_ph[3]  <= r_ph[2];
            r_pk2    <= MW'(r_ph[1]) * MW'(RK);
            r_ke3    <= w_ke;
            r_km3    <= w_km[REM_W-1:0];
            r_a4     <= w_k[A-1:0];
            r_quad4  <= w_k[K_W-1 -: 2];
            r_sa5    <= w_rom[{1'b0, r_a4}];
            r_sb5    <= w_rom[ROM_TOP - {1'b0, r_a4}];
            r_quad5  <= r_quad4;
            r_ic6    <= w_si5 * w_c;
            r_qs6    <= w_sq5 * w_s;
            r_is6    <= w_si5 * w_s;
            r_qc6    <= w_sq5 * w_c;
            r_res7   <= {round_sat(w_vi), round_sat(w_vq), r_pay[6][REST_W-1:0]};
        end
    end

endmodule

@@ tb/mix_level_checker.sv @@
`timescale 1ns / 1ps
// Checker for the frequency-shift mixer: watches both queue ports, predicts each result
// from its own phase, table and average state, and counts mismatches.
// Depends on nfs_pkg for the offset width and the average shifts.
module mix_level_checker #(
    parameter int PHASE_MOD = 2048000,
    parameter int ROM_BITS  = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    input  logic                            full,
    input  logic signed [15:0]              i_sample_i,
    input  logic signed [15:0]              i_sample_q,
    input  logic signed [nfs_pkg::PH_W-1:0] i_freq_offset,
    input  logic                            i_last_of_block,
    input  logic                            empty,
    input  logic                            pop,
    input  logic signed [15:0]              i_out_i,
    input  logic signed [15:0]              i_out_q,
    input  logic [15:0]                     i_signal_level,
    input  logic [15:0]                     i_avg_abs_i,
    input  logic [15:0]                     i_avg_abs_q,
    input  logic                            i_block_end,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam int QUARTER = 1 << ROM_BITS;
    // one tenth of full scale in the level format, rounded
    localparam logic [63:0] LEVEL_START = ((64'd1 << 32) + 64'd5) / 64'd10;

    typedef struct {
        logic signed [15:0] out_i;
        logic signed [15:0] out_q;
        logic [15:0]        level;
        logic [15:0]        avg_i;
        logic [15:0]        avg_q;
        logic               block_end;
    } t_mixed_sample;

    t_mixed_sample mixed_samples[$];
    longint        sine_q15[0:QUARTER];
    longint        phase_acc;
    logic [63:0]   abs_i_avg;
    logic [63:0]   abs_q_avg;
    logic [63:0]   level_avg;
    int            fails;
    int            waiting;

    assign o_fail_count = fails;
    assign o_pending    = waiting;

    // Odd Taylor series of sin(pi/2 * x) in Q30, Horner form, rounded to Q1.15
    function automatic longint quarter_sine(input int addr);
        logic [4:0][63:0] coef;
        logic [63:0]      x;
        logic [63:0]      x2;
        logic [63:0]      acc;
        int               j;
        coef = {64'd172272, 64'd5026995, 64'd85569306, 64'd693598669, 64'd1686629713};
        x    = 64'(addr) << (30 - ROM_BITS);
        x2   = (x * x) >> 30;
        acc  = coef[4];
        for (j = 3; j >= 0; j--) begin
            acc = coef[j] - ((x2 * acc) >> 30);
        end
        acc = (((x * acc) >> 30) + 64'd16384) >> 15;
        return (acc > 64'd32767) ? 64'sd32767 : longint'(acc);
    endfunction

    // Round half up from Q2.30 to Q1.15 and clamp
    function automatic logic signed [15:0] round_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endtask

    // Advance the averages and the phase by one sample, then rotate it
    task automatic mix_and_track(input logic signed [15:0] si, input logic signed [15:0] sq,
                                 input logic signed [nfs_pkg::PH_W-1:0] off,
                                 input logic last, output t_mixed_sample r);
        longint      iv;
        longint      qv;
        longint      mag_i;
        longint      mag_q;
        longint      c;
        longint      s;
        longint      sa;
        longint      sb;
        logic [63:0] idx;
        logic [63:0] lvl;
        int          addr;
        iv    = si;
        qv    = sq;
        mag_i = (iv < 0) ? -iv : iv;
        mag_q = (qv < 0) ? -qv : qv;
        abs_i_avg = abs_i_avg - (abs_i_avg >> nfs_pkg::AVG_SHIFT) + 64'(mag_i);
        abs_q_avg = abs_q_avg - (abs_q_avg >> nfs_pkg::AVG_SHIFT) + 64'(mag_q);
        level_avg = level_avg - (level_avg >> nfs_pkg::LEVEL_SHIFT) + 64'(mag_i + mag_q);

        // step the phase back by the offset, keep the non-negative residue
        phase_acc = (phase_acc - longint'(off)) % PHASE_MOD;
        if (phase_acc < 0) begin
            phase_acc += PHASE_MOD;
        end

        idx  = 64'(phase_acc << (ROM_BITS + 2)) / 64'(PHASE_MOD);
        addr = int'(idx % QUARTER);
        sa   = sine_q15[addr];
        sb   = sine_q15[QUARTER - addr];
        case ((idx >> ROM_BITS) & 64'd3)
            64'd0: begin c = sb;  s = sa;  end
            64'd1: begin c = -sa; s = sb;  end
            64'd2: begin c = -sb; s = -sa; end
            default: begin c = sa; s = -sb; end
        endcase

        r.out_i     = round_q15(iv * c - qv * s);
        r.out_q     = round_q15(iv * s + qv * c);
        lvl         = level_avg >> nfs_pkg::LEVEL_SHIFT;
        r.level     = (lvl > 64'd65535) ? 16'hFFFF : lvl[15:0];
        r.avg_i     = 16'(abs_i_avg >> nfs_pkg::AVG_SHIFT);
        r.avg_q     = 16'(abs_q_avg >> nfs_pkg::AVG_SHIFT);
        r.block_end = last;
    endtask

    initial begin
        fails   = 0;
        waiting = 0;
        for (int a = 0; a <= QUARTER; a++) begin
            sine_q15[a] = quarter_sine(a);
        end
    end

    // Compare each popped result with the oldest prediction, then predict for each request
    always @(posedge i_clk) begin : watch
        t_mixed_sample want;
        t_mixed_sample made;
        if (!i_rst_n) begin
            phase_acc = 0;
            abs_i_avg = '0;
            abs_q_avg = '0;
            level_avg = LEVEL_START;
            mixed_samples.delete();
        end else begin
            if (pop && !empty) begin
                if (mixed_samples.size() == 0) begin
                    $display("%0t: result with nothing expected, got i=%0d q=%0d level=%0d",
                             $time, i_out_i, i_out_q, i_signal_level);
                    fails++;
                end else begin
                    want = mixed_samples.pop_front();
                    check_field("out_i", want.out_i, i_out_i);
                    check_field("out_q", want.out_q, i_out_q);
                    check_field("signal_level", want.level, i_signal_level);
                    check_field("avg_abs_i", want.avg_i, i_avg_abs_i);
                    check_field("avg_abs_q", want.avg_q, i_avg_abs_q);
                    check_field("block_end", want.block_end, i_block_end);
                end
            end
            if (push && !full) begin
                mix_and_track(i_sample_i, i_sample_q, i_freq_offset, i_last_of_block, made);
                mixed_samples.push_back(made);
            end
        end
        waiting = mixed_samples.size();
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Top of the mixer testbench: clock, reset, sample stimulus, result draining and verdict.
// Depends on nfs_pkg, the mixer unit and mix_level_checker.
module tb;

    localparam int LIMIT        = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1600;
    localparam int TAIL_CYCLES  = 40;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            push;
    logic                            full;
    logic signed [15:0]              sample_i;
    logic signed [15:0]              sample_q;
    logic signed [nfs_pkg::PH_W-1:0] freq_offset;
    logic                            last_of_block;
    logic                            empty;
    logic                            pop;
    logic signed [15:0]              out_i;
    logic signed [15:0]              out_q;
    logic [15:0]                     signal_level;
    logic [15:0]                     avg_abs_i;
    logic [15:0]                     avg_abs_q;
    logic                            block_end;
    int                              fail_count;
    int                              pending;
    int                              cycle_count;
    int                              rx_cycles;
    bit                              calm;

    nco_frequency_shift_with_level_track_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_sample_i      (sample_i),
        .i_sample_q      (sample_q),
        .i_freq_offset   (freq_offset),
        .i_last_of_block (last_of_block),
        .empty           (empty),
        .pop             (pop),
        .o_out_i         (out_i),
        .o_out_q         (out_q),
        .o_signal_level  (signal_level),
        .o_avg_abs_i     (avg_abs_i),
        .o_avg_abs_q     (avg_abs_q),
        .o_block_end     (block_end)
    );

    mix_level_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_sample_i      (sample_i),
        .i_sample_q      (sample_q),
        .i_freq_offset   (freq_offset),
        .i_last_of_block (last_of_block),
        .empty           (empty),
        .pop             (pop),
        .i_out_i         (out_i),
        .i_out_q         (out_q),
        .i_signal_level  (signal_level),
        .i_avg_abs_i     (avg_abs_i),
        .i_avg_abs_q     (avg_abs_q),
        .i_block_end     (block_end),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up once the cycle budget is spent
    initial begin
        cycle_count = 0;
        while (cycle_count <= LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Pop at random, with one long hold-off while requests keep arriving
    initial begin
        pop       = 1'b0;
        rx_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            rx_cycles++;
            if (rx_cycles == 900) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                pop <= calm || ($urandom_range(99) >= 15);
            end
        end
    end

    // Offer one request and hold it until the unit takes it
    task automatic offer(input logic signed [15:0] si, input logic signed [15:0] sq,
                         input logic signed [nfs_pkg::PH_W-1:0] off, input logic last);
        @(negedge i_clk);
        if (!calm) begin
            while ($urandom_range(99) < 15) begin
                push <= 1'b0;
                @(negedge i_clk);
            end
        end
        push          <= 1'b1;
        sample_i      <= si;
        sample_q      <= sq;
        freq_offset   <= off;
        last_of_block <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // Stop offering until every predicted result has been popped
    task automatic drain_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // Mostly uniform samples, a quarter of them at the rails or near zero
    function automatic logic signed [15:0] pick_sample();
        if ($urandom_range(3) != 0) begin
            return 16'($urandom);
        end
        case ($urandom_range(4))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return -16'sd1;
            3: return 16'sd0;
            default: return 16'sd1;
        endcase
    endfunction

    initial begin : stimulus
        int                              sent;
        int                              len;
        int                              mode;
        bit                              noise;
        bit                              drained;
        logic signed [nfs_pkg::PH_W-1:0] off;

        push          = 1'b0;
        sample_i      = '0;
        sample_q      = '0;
        freq_offset   = '0;
        last_of_block = 1'b0;
        calm          = 1'b0;
        drained       = 1'b0;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // walk the quadrant boundaries, then the extreme offsets
        offer(16'sd0, 16'sd0, 21'sd0, 1'b0);
        offer(16'sd32767, -16'sd32768, -21'sd256000, 1'b0);   // 45 degrees, out_i clips high
        offer(-16'sd32768, -16'sd32768, 21'sd0, 1'b0);        // out_q clips low
        offer(16'sd32767, 16'sd0, -21'sd256000, 1'b0);        // 90 degrees
        offer(-16'sd32768, 16'sd32767, -21'sd512000, 1'b0);   // 180 degrees
        offer(16'sd12345, -16'sd12345, -21'sd512000, 1'b0);   // 270 degrees
        offer(16'sd32767, 16'sd32767, -21'sd512000, 1'b1);    // wrap to zero
        offer(-16'sd1, -16'sd1, 21'sd1048575, 1'b0);          // largest positive offset, past half the modulus
        offer(16'sd1, 16'sd1, -21'sd1048576, 1'b0);
        offer(16'sd32767, 16'sd32767, 21'sd1024000, 1'b1);
        offer(-16'sd32768, -16'sd32768, -21'sd1024000, 1'b0);
        offer(-16'sd32768, 16'sd0, 21'sd1, 1'b0);
        offer(16'sd0, -16'sd32768, 21'sd2, 1'b0);             // small negative wrap
        offer(16'sd32767, -16'sd32768, -21'sd1, 1'b1);
        offer(-16'sd32768, 16'sd32767, -21'sd128000, 1'b0);   // 22.5 degrees steps
        offer(16'sd32767, 16'sd32767, -21'sd128000, 1'b0);
        offer(-16'sd32768, -16'sd32768, -21'sd128000, 1'b0);
        offer(16'sd21845, -16'sd21846, 21'sd777, 1'b1);
        drain_results();

        // blocks of samples sharing one offset, with some stray single samples
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = (sent >= 500 && sent < 800);
            if (sent >= 1100 && !drained) begin
                drain_results();
                drained = 1'b1;
            end
            mode = $urandom_range(9);
            if (mode < 6) begin
                off = 21'($urandom_range(2048000) - 1024000);
            end else if (mode == 6) begin
                off = 21'($urandom_range(2000) - 1000);
            end else if (mode == 7) begin
                off = '0;
            end else begin
                off = 21'($urandom);
            end
            noise = ($urandom_range(7) == 0);
            len   = noise ? 1 : $urandom_range(24, 1);
            for (int j = 0; j < len; j++) begin
                offer(pick_sample(), pick_sample(), off,
                      noise ? 1'($urandom_range(1)) : (j == len - 1));
                sent++;
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
